// ----- src/aimd_pkg.sv -----
// ----------------------------------------------------------------------------
// AIMD rate throttle package
// Types, register indexes, fixed-point constants and sequencer states that
// are shared by the throttle unit and its checker.
// ----------------------------------------------------------------------------
package aimd_pkg;

   localparam logic [16:0] ONE_Q16       = 17'h10000;
   localparam logic [9:0]  DRIFT_Q16     = 10'd655;
   localparam logic [16:0] MAX_INTERVAL  = 17'd16;
   localparam logic [31:0] EVAL_INTERVAL = 32'd1;
   localparam logic [23:0] ROUND_HALF    = 24'd32768;

   localparam int DIV_STEPS  = 17;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int SEND_W     = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_MARGIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_THR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKLOG_THR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_FLOOR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEC_FACTOR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INC_STEP     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BUDGET_FLOOR = 3'd7;

   typedef struct packed {
      logic [31:0] tick_now;
      logic [15:0] rtt_ms;
      logic [16:0] loss_fraction;
      logic [23:0] bytes_in_flight;
      logic [23:0] static_budget;
   } aimd_req_type;

   typedef struct packed {
      logic [SEND_W-1:0] send_interval;
      logic [23:0]       budget_out;
      logic [16:0]       throttle_out;
      logic              was_evaluated;
      logic              was_congested;
   } aimd_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_DRIFT,
      ST_GATE,
      ST_DEC,
      ST_SCALE,
      ST_DIV,
      ST_DONE
   } aimd_state_type;

endpackage

// ----- src/aimd_rate_throttle_unit.sv -----
// ----------------------------------------------------------------------------
// AIMD rate throttle unit
// Keeps an RTT baseline and a Q1.16 throttle, steps the throttle once per
// evaluation interval, and reports send interval and scaled byte budget.
// ----------------------------------------------------------------------------
// When enabled, a request goes through the baseline, gate and throttle states,
// a scaling state and the 17-step restoring divider for the send interval;
// when disabled it goes straight to the done state. No new request is taken
// until the current response is issued. Reset is synchronous and active high; it restores
// the registers, baseline, gate, throttle and handshake state, not the datapath.
module aimd_rate_throttle_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  aimd_pkg::aimd_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output aimd_pkg::aimd_rsp_type               rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [aimd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [aimd_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import aimd_pkg::*;

   aimd_state_type state_ff, state_in;

   logic        enabled_ff;
   logic [15:0] delay_margin_ff;
   logic [16:0] loss_thr_ff;
   logic [23:0] backlog_thr_ff;
   logic [16:0] thr_floor_ff;
   logic [15:0] dec_factor_ff;
   logic [16:0] inc_step_ff;
   logic [23:0] budget_floor_ff;

   logic [31:0] base_ff, base_in;
   logic        base_valid_ff, base_valid_in;
   logic        eval_seen_ff, eval_seen_in;
   logic [31:0] last_tick_ff, last_tick_in;
   logic [16:0] throttle_ff, throttle_in;
   logic        evaluated_ff, evaluated_in;
   logic        congested_ff, congested_in;
   logic        dis_ff, dis_in;
   logic        rsp_valid_ff, rsp_valid_in;
   aimd_rsp_type rsp_data_ff, rsp_data_in;

   aimd_req_type         item_ff, item_in;
   logic [48:0]          prod_ff, prod_in;
   logic [16:0]          div_num_ff, div_num_in;
   logic [16:0]          div_rem_ff, div_rem_in;
   logic [16:0]          div_quo_ff, div_quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic        req_accept;
   logic        out_free;
   logic [31:0] mul_a;
   logic [16:0] mul_b;
   logic [48:0] mul_p;
   logic [31:0] rtt_q;
   logic        base_lower;
   logic        gated;
   logic        rtt_cong;
   logic        cong;
   logic [17:0] inc_sum;
   logic [16:0] thr_inc;
   logic [16:0] eff_floor;
   logic [16:0] thr_dec;
   logic [17:0] rem_shift;
   logic        div_fits;
   logic [17:0] rem_sub;
   logic [17:0] div_seed;
   logic [16:0] quo_clamp;
   logic [41:0] round_sum;
   logic [23:0] scaled;
   logic [23:0] bud_floor;
   logic [23:0] budget;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign rtt_q      = {item_ff.rtt_ms, 16'h0000};
   assign base_lower = !base_valid_ff || (rtt_q < base_ff);
   assign gated      = eval_seen_ff && ((item_ff.tick_now - last_tick_ff) < EVAL_INTERVAL);
   assign rtt_cong   = (rtt_q > base_ff) &&
                       ((item_ff.rtt_ms - base_ff[31:16]) > delay_margin_ff);
   assign cong       = (item_ff.loss_fraction > loss_thr_ff) || rtt_cong ||
                       (item_ff.bytes_in_flight > backlog_thr_ff);

   assign inc_sum = {1'b0, throttle_ff} + {1'b0, inc_step_ff};
   assign thr_inc = (inc_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : inc_sum[16:0];

   always_comb begin
      eff_floor = thr_floor_ff;
      if (thr_floor_ff == 17'd0) begin
         eff_floor = 17'd1;
      end else if (thr_floor_ff > ONE_Q16) begin
         eff_floor = ONE_Q16;
      end
   end

   assign thr_dec = (prod_ff[32:16] > eff_floor) ? prod_ff[32:16] : eff_floor;

   always_comb begin
      unique case (state_ff)
         ST_BASE: begin
            mul_a = rtt_q - base_ff;
            mul_b = {7'd0, DRIFT_Q16};
         end
         ST_GATE: begin
            mul_a = {15'd0, throttle_ff};
            mul_b = {1'b0, dec_factor_ff};
         end
         default: begin
            mul_a = {8'd0, item_ff.static_budget};
            mul_b = throttle_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign rem_shift = {div_rem_ff, div_num_ff[16]};
   assign div_fits  = rem_shift >= {1'b0, throttle_ff};
   assign rem_sub   = rem_shift - {1'b0, throttle_ff};
   assign div_seed  = {1'b0, ONE_Q16} + {1'b0, throttle_ff} - 18'd1;

   always_comb begin
      quo_clamp = div_quo_ff;
      if (div_quo_ff == 17'd0) begin
         quo_clamp = 17'd1;
      end else if (div_quo_ff > MAX_INTERVAL) begin
         quo_clamp = MAX_INTERVAL;
      end
   end

   assign round_sum = {1'b0, prod_ff[40:0]} + {18'd0, ROUND_HALF};
   assign scaled    = round_sum[39:16];
   assign bud_floor = (budget_floor_ff > item_ff.static_budget) ?
                      item_ff.static_budget : budget_floor_ff;
   assign budget    = (item_ff.static_budget == 24'd0) ? 24'd0 :
                      ((scaled > bud_floor) ? scaled : bud_floor);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = enabled_ff ? ST_BASE : ST_DONE;
            end
         end
         ST_BASE: begin
            state_in = base_lower ? ST_GATE : ST_DRIFT;
         end
         ST_DRIFT: begin
            state_in = ST_GATE;
         end
         ST_GATE: begin
            state_in = (!gated && cong) ? ST_DEC : ST_SCALE;
         end
         ST_DEC: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      item_in       = item_ff;
      prod_in       = prod_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      base_in       = base_ff;
      base_valid_in = base_valid_ff;
      eval_seen_in  = eval_seen_ff;
      last_tick_in  = last_tick_ff;
      throttle_in   = throttle_ff;
      evaluated_in  = evaluated_ff;
      congested_in  = congested_ff;
      dis_in        = dis_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in = req_data;
               dis_in  = !enabled_ff;
               if (!enabled_ff) begin
                  throttle_in = ONE_Q16;
               end
            end
         end
         ST_BASE: begin
            if (base_lower) begin
               base_in       = rtt_q;
               base_valid_in = 1'b1;
            end else begin
               prod_in = mul_p;
            end
         end
         ST_DRIFT: begin
            base_in = base_ff + prod_ff[47:16];
         end
         ST_GATE: begin
            evaluated_in = !gated;
            congested_in = !gated && cong;
            if (!gated) begin
               eval_seen_in = 1'b1;
               last_tick_in = item_ff.tick_now;
               if (cong) begin
                  prod_in = mul_p;
               end else begin
                  throttle_in = thr_inc;
               end
            end
         end
         ST_DEC: begin
            throttle_in = thr_dec;
         end
         ST_SCALE: begin
            prod_in    = mul_p;
            div_num_in = div_seed[16:0];
            div_rem_in = 17'd0;
            div_quo_in = 17'd0;
            div_cnt_in = DIV_CNT_W'(DIV_STEPS);
         end
         ST_DIV: begin
            div_num_in = {div_num_ff[15:0], 1'b0};
            div_rem_in = div_fits ? rem_sub[16:0] : rem_shift[16:0];
            div_quo_in = {div_quo_ff[15:0], div_fits};
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (dis_ff) begin
                  rsp_data_in.send_interval = SEND_W'(1);
                  rsp_data_in.budget_out    = item_ff.static_budget;
                  rsp_data_in.throttle_out  = ONE_Q16;
                  rsp_data_in.was_evaluated = 1'b0;
                  rsp_data_in.was_congested = 1'b0;
               end else begin
                  rsp_data_in.send_interval = quo_clamp[SEND_W-1:0];
                  rsp_data_in.budget_out    = budget;
                  rsp_data_in.throttle_out  = throttle_ff;
                  rsp_data_in.was_evaluated = evaluated_ff;
                  rsp_data_in.was_congested = congested_ff;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         enabled_ff      <= 1'b0;
         delay_margin_ff <= 16'd50;
         loss_thr_ff     <= 17'd3277;
         backlog_thr_ff  <= 24'd65536;
         thr_floor_ff    <= 17'd16384;
         dec_factor_ff   <= 16'd49152;
         inc_step_ff     <= 17'd3277;
         budget_floor_ff <= 24'd1024;
         base_ff         <= 32'd0;
         base_valid_ff   <= 1'b0;
         eval_seen_ff    <= 1'b0;
         last_tick_ff    <= 32'd0;
         throttle_ff     <= ONE_Q16;
         evaluated_ff    <= 1'b0;
         congested_ff    <= 1'b0;
         dis_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         base_valid_ff <= base_valid_in;
         eval_seen_ff  <= eval_seen_in;
         last_tick_ff  <= last_tick_in;
         throttle_ff   <= throttle_in;
         evaluated_ff  <= evaluated_in;
         congested_ff  <= congested_in;
         dis_ff        <= dis_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ENABLED:      enabled_ff      <= csr_wr_data[0];
               CSR_DELAY_MARGIN: delay_margin_ff <= csr_wr_data[15:0];
               CSR_LOSS_THR:     loss_thr_ff     <= csr_wr_data[16:0];
               CSR_BACKLOG_THR:  backlog_thr_ff  <= csr_wr_data[23:0];
               CSR_THR_FLOOR:    thr_floor_ff    <= csr_wr_data[16:0];
               CSR_DEC_FACTOR:   dec_factor_ff   <= csr_wr_data[15:0];
               CSR_INC_STEP:     inc_step_ff     <= csr_wr_data[16:0];
               CSR_BUDGET_FLOOR: budget_floor_ff <= csr_wr_data[23:0];
               default:          enabled_ff      <= enabled_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      prod_ff     <= prod_in;
      div_num_ff  <= div_num_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- src/aimd_checker.sv -----
// ----------------------------------------------------------------------------
// AIMD rate throttle checker
// Port-level assertions on the throttle unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module aimd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input aimd_pkg::aimd_rsp_type          rsp_data
);
   import aimd_pkg::*;

   // A request in flight keeps the input side closed on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a request was still in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.send_interval != SEND_W'(0) &&
                    {12'd0, rsp_data.send_interval} <= MAX_INTERVAL)
      else $error("send interval out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.throttle_out != 17'd0 &&
                    rsp_data.throttle_out <= ONE_Q16)
      else $error("throttle out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.was_evaluated |-> !rsp_data.was_congested)
      else $error("congestion reported without an evaluation");

endmodule

bind aimd_rate_throttle_unit aimd_checker u_aimd_checker (.*);
